FILE: src/assert_macros.svh
// Assertion macros used by the sorted priority queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

FILE: src/spq_pkg.sv
// Package with the types, constants and codes of the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

   // Number of cells in the chain; count width holds 0 through DEPTH.
   localparam int DEPTH         = 16;
   localparam int COUNT_W       = $clog2(DEPTH + 1);
   localparam int ENTRY_COUNT_W = 5;

   // Operation codes carried in the mode field.
   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_PEEK   = 2'd1;
   localparam logic [1:0] MODE_POP    = 2'd2;

   // Error codes reported with every result.
   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_FULL  = 2'd1;
   localparam logic [1:0] ERR_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] new_priority;
      logic [15:0] new_tag;
   } req_item_type;

   typedef struct packed {
      logic [15:0]              out_priority;
      logic [15:0]              out_tag;
      logic                     out_valid;
      logic                     queue_empty;
      logic                     queue_full;
      logic [1:0]               error_code;
      logic [ENTRY_COUNT_W-1:0] entry_count;
   } rsp_item_type;

   // One stored queue entry.
   typedef struct packed {
      logic [15:0] prio;
      logic [15:0] tag;
   } entry_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic      do_insert;
      logic      do_pop;
      entry_type new_entry;
   } cell_ctrl_type;

endpackage

FILE: src/spq_cell.sv
// One cell of the sorted register chain: holds one entry and shifts with its neighbors.
`timescale 1ns / 1ps

module spq_cell (
   input  logic                  clock,
   input  spq_pkg::cell_ctrl_type ctrl,
   input  logic                  occupied,
   input  logic                  left_greater,
   input  spq_pkg::entry_type    left_entry,
   input  spq_pkg::entry_type    right_entry,
   output logic                  greater,
   output spq_pkg::entry_type    entry
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   // The new entry belongs at or before this cell when the cell is empty or
   // holds a strictly larger priority, so equal priorities keep arrival order.
   assign greater = !occupied || (entry_ff.prio > ctrl.new_entry.prio);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.do_insert) begin
         if (left_greater) begin
            entry_in = left_entry;
         end else if (greater) begin
            entry_in = ctrl.new_entry;
         end
      end else if (ctrl.do_pop) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

FILE: src/sorted_priority_queue.sv
// Top level of the sorted priority queue built as a chain of compare-and-shift cells.
// A result item enters the output register in the cycle after its request item is taken.
// Throughput: one item per cycle; every cell compares against the new priority at once.
// An item is taken whenever the output register is empty or being drained.
// Reset clears the entry count and the output valid; cell contents stay unset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sorted_priority_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  spq_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output spq_pkg::rsp_item_type rsp_item
);

   // Number of entries held; cells at or above this index are empty.
   logic [spq_pkg::COUNT_W-1:0] count_ff;
   logic [spq_pkg::COUNT_W-1:0] count_in;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   spq_pkg::rsp_item_type rsp_item_ff;
   spq_pkg::rsp_item_type rsp_item_in;

   logic                  req_accept;
   logic                  is_insert;
   logic                  is_pop;
   logic                  is_empty;
   logic                  is_full;
   spq_pkg::cell_ctrl_type ctrl;

   spq_pkg::entry_type cell_entry   [spq_pkg::DEPTH];
   logic               cell_greater [spq_pkg::DEPTH];

   // The output register frees the input side: a new item enters whenever the
   // held result is absent or leaves in the same cycle.
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == spq_pkg::COUNT_W'(spq_pkg::DEPTH));
   assign is_insert = (req_item.mode == spq_pkg::MODE_INSERT);
   assign is_pop    = (req_item.mode == spq_pkg::MODE_POP);

   // An insert into a full queue and a pop from an empty queue leave the chain
   // untouched.
   always_comb begin
      ctrl.do_insert           = req_accept && is_insert && !is_full;
      ctrl.do_pop              = req_accept && is_pop && !is_empty;
      ctrl.new_entry.prio      = req_item.new_priority;
      ctrl.new_entry.tag       = req_item.new_tag;
   end

   // The cell chain. Each cell looks at its left neighbor's compare result to
   // learn whether the insert point lies strictly before it, in which case it
   // takes its left neighbor's entry. A pop shifts every entry one cell left.
   for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
      logic               left_greater;
      spq_pkg::entry_type left_entry;
      spq_pkg::entry_type right_entry;

      if (i == 0) begin : g_first
         assign left_greater = 1'b0;
         assign left_entry   = '0;
      end else begin : g_inner_left
         assign left_greater = cell_greater[i-1];
         assign left_entry   = cell_entry[i-1];
      end

      if (i == spq_pkg::DEPTH - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_inner_right
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .occupied     (count_ff > spq_pkg::COUNT_W'(i)),
         .left_greater (left_greater),
         .left_entry   (left_entry),
         .right_entry  (right_entry),
         .greater      (cell_greater[i]),
         .entry        (cell_entry[i])
      );
   end

   // Result formation. An insert reports the front after insertion, which is
   // the new entry when it lands in the first cell. Peek and pop report the
   // front before the operation; the unused mode code acts as a peek.
   always_comb begin
      count_in    = count_ff;
      rsp_item_in = rsp_item_ff;

      if (req_accept) begin
         rsp_item_in.error_code   = spq_pkg::ERR_NONE;
         rsp_item_in.out_valid    = 1'b1;
         rsp_item_in.out_priority = cell_entry[0].prio;
         rsp_item_in.out_tag      = cell_entry[0].tag;

         if (is_insert) begin
            if (is_full) begin
               rsp_item_in.error_code = spq_pkg::ERR_FULL;
            end else begin
               count_in = count_ff + 1'b1;
               if (cell_greater[0]) begin
                  rsp_item_in.out_priority = req_item.new_priority;
                  rsp_item_in.out_tag      = req_item.new_tag;
               end
            end
         end else if (is_empty) begin
            rsp_item_in.error_code   = spq_pkg::ERR_EMPTY;
            rsp_item_in.out_valid    = 1'b0;
            rsp_item_in.out_priority = '0;
            rsp_item_in.out_tag      = '0;
         end else if (is_pop) begin
            count_in = count_ff - 1'b1;
         end

         rsp_item_in.queue_empty = (count_in == '0);
         rsp_item_in.queue_full  = (count_in == spq_pkg::COUNT_W'(spq_pkg::DEPTH));
         rsp_item_in.entry_count = spq_pkg::ENTRY_COUNT_W'(count_in);
      end
   end

   // The output register loads on every accepted item and empties when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // The count never exceeds the number of cells.
   `ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= spq_pkg::COUNT_W'(spq_pkg::DEPTH))

   // The two front cells stay in priority order whenever both are occupied.
   `ASSERT_SAME(a_front_sorted, clock, reset, count_ff >= spq_pkg::COUNT_W'(2), cell_entry[0].prio <= cell_entry[1].prio)

   // A dropped insert leaves the count alone.
   `ASSERT_NEXT(a_full_drop, clock, reset, req_accept && is_insert && is_full, $stable(count_ff))

   // A pop on a non-empty queue removes exactly one entry.
   `ASSERT_NEXT(a_pop_count, clock, reset, ctrl.do_pop, count_ff == $past(count_ff) - 1'b1)

   // A reported entry count follows the held count after the operation.
   `ASSERT_NEXT(a_rsp_count, clock, reset, req_accept, rsp_item_ff.entry_count == spq_pkg::ENTRY_COUNT_W'(count_ff))

endmodule

FILE: sim/tb_sorted_priority_queue.sv
// Self-checking testbench for the sorted priority queue with a scoreboard and random idling.
`timescale 1ns / 1ps

module tb_sorted_priority_queue;

   // The mode field has one code that the block treats as a peek.
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // Longest run of cycles with no item moving on either channel. In a correct run the
   // idle stretches come only from sender gaps, receiver stalls and the output register.
   localparam int IDLE_LIMIT   = 400;
   localparam int RANDOM_ITEMS = 1200;

   // The scoreboard keeps its own sorted copy of the queue. Every accepted request item
   // is applied to that copy at once, and the status that the block must report for it
   // is queued until the matching result item comes out.
   class queue_tracker;
      spq_pkg::entry_type    slots[spq_pkg::DEPTH];
      int unsigned           held;
      spq_pkg::rsp_item_type predicted[$];
      int unsigned           fail_count;
      int unsigned           checked;
      int unsigned           inserts;
      int unsigned           pops;
      int unsigned           peeks;
      int unsigned           full_drops;
      int unsigned           empty_errors;
      int unsigned           full_seen;

      task report(input string msg);
         $display("%0t ns mismatch: %s", $time, msg);
         fail_count++;
      endtask

      // Applies one operation to the shadow queue and records the status it causes.
      task note_request(input spq_pkg::req_item_type item);
         spq_pkg::rsp_item_type r;
         int unsigned           pos;
         int unsigned           idx;
         r = '0;
         if (item.mode == spq_pkg::MODE_INSERT) begin
            inserts++;
            if (held >= spq_pkg::DEPTH) begin
               // The new entry is dropped; the unchanged front is still reported.
               r.error_code = spq_pkg::ERR_FULL;
               full_drops++;
            end else begin
               // A new entry goes behind every entry of equal or lower priority.
               pos = 0;
               while (pos < held && slots[pos].prio <= item.new_priority) pos++;
               for (idx = held; idx > pos; idx--) slots[idx] = slots[idx - 1];
               slots[pos] = {item.new_priority, item.new_tag};
               held++;
            end
            r.out_priority = slots[0].prio;
            r.out_tag      = slots[0].tag;
            r.out_valid    = 1'b1;
         end else begin
            if (item.mode == spq_pkg::MODE_POP) pops++;
            else peeks++;
            if (held == 0) begin
               r.error_code = spq_pkg::ERR_EMPTY;
               empty_errors++;
            end else begin
               r.out_priority = slots[0].prio;
               r.out_tag      = slots[0].tag;
               r.out_valid    = 1'b1;
               if (item.mode == spq_pkg::MODE_POP) begin
                  for (idx = 0; idx + 1 < held; idx++) slots[idx] = slots[idx + 1];
                  held--;
               end
            end
         end
         r.queue_empty = (held == 0);
         r.queue_full  = (held == spq_pkg::DEPTH);
         r.entry_count = spq_pkg::ENTRY_COUNT_W'(held);
         if (held == spq_pkg::DEPTH) full_seen++;
         predicted.push_back(r);
      endtask

      // Compares a result item with the oldest predicted status, one field at a time.
      task check_result(input spq_pkg::rsp_item_type got);
         spq_pkg::rsp_item_type want;
         if (predicted.size() == 0) begin
            report($sformatf("result item %h arrived with nothing predicted", got));
            return;
         end
         want = predicted.pop_front();
         checked++;
         if (got.out_priority !== want.out_priority)
            report($sformatf("out_priority %h, predicted %h", got.out_priority,
                             want.out_priority));
         if (got.out_tag !== want.out_tag)
            report($sformatf("out_tag %h, predicted %h", got.out_tag, want.out_tag));
         if (got.out_valid !== want.out_valid)
            report($sformatf("out_valid %b, predicted %b", got.out_valid, want.out_valid));
         if (got.queue_empty !== want.queue_empty)
            report($sformatf("queue_empty %b, predicted %b", got.queue_empty,
                             want.queue_empty));
         if (got.queue_full !== want.queue_full)
            report($sformatf("queue_full %b, predicted %b", got.queue_full,
                             want.queue_full));
         if (got.error_code !== want.error_code)
            report($sformatf("error_code %0d, predicted %0d", got.error_code,
                             want.error_code));
         if (got.entry_count !== want.entry_count)
            report($sformatf("entry_count %0d, predicted %0d", got.entry_count,
                             want.entry_count));
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   spq_pkg::req_item_type req_item;
   logic                  rsp_valid;
   logic                  rsp_stall;
   spq_pkg::rsp_item_type rsp_item;

   // When set, the sender puts its items back to back for the current stretch.
   logic         req_quiet;

   queue_tracker tracker = new();

   sorted_priority_queue dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Both channels are sampled at the rising edge, before any update of that edge lands.
   // The request is noted first so that a result of the same edge would still find it.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) tracker.note_request(req_item);
         if (rsp_valid && !rsp_stall) tracker.check_result(rsp_item);
      end
   end

   // The receiver draws a random stall for every result item. Every
   // forty results it may switch to a stretch in which it never stalls.
   initial begin : result_receiver
      int unsigned hold;
      int unsigned taken;
      logic        quiet;
      taken = 0;
      quiet = 1'b0;
      forever begin
         if (taken % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
         hold = quiet ? 0 : $urandom_range(0, 9);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (reset || !rsp_valid) @(posedge clock);
         taken++;
      end
   end

   // The run ends in failure if no item moves on either channel for too long.
   initial begin : watchdog
      int unsigned idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle = 0;
         else idle++;
      end
      $display("Stopped after %0d cycles without progress.", IDLE_LIMIT);
      $display("FAILURE");
      $finish;
   end

   // Offers one request item after a random gap and returns at the edge that takes it.
   // Valid is lowered only when a gap follows, so it is never dropped and raised again
   // within one step.
   task automatic send_request(input logic [1:0] mode, input logic [15:0] prio,
                               input logic [15:0] tag);
      int unsigned gap;
      gap = req_quiet ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= {mode, prio, tag};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Random traffic in stretches of forty items. A filling stretch is mostly inserts and
   // drives the queue into its full state, a draining stretch is mostly pops and empties
   // it, and a mixed stretch keeps the queue around its middle. Half of the priorities
   // come from a narrow range so that ties are common.
   task automatic run_random(input int unsigned count);
      int unsigned n;
      int unsigned bias;
      int unsigned roll;
      logic [1:0]  mode;
      logic [15:0] prio;
      bias = 0;
      for (n = 0; n < count; n++) begin
         if (n % 40 == 0) begin
            bias      = $urandom_range(0, 2);
            req_quiet = ($urandom_range(0, 3) == 0);
         end
         roll = $urandom_range(0, 99);
         case (bias)
            0: begin
               mode = (roll < 80) ? spq_pkg::MODE_INSERT :
                      (roll < 92) ? spq_pkg::MODE_POP : spq_pkg::MODE_PEEK;
            end
            1: begin
               mode = (roll < 20) ? spq_pkg::MODE_INSERT :
                      (roll < 85) ? spq_pkg::MODE_POP : spq_pkg::MODE_PEEK;
            end
            default: begin
               mode = (roll < 45) ? spq_pkg::MODE_INSERT :
                      (roll < 85) ? spq_pkg::MODE_POP : spq_pkg::MODE_PEEK;
            end
         endcase
         if (mode == spq_pkg::MODE_PEEK && $urandom_range(0, 4) == 0) mode = MODE_UNUSED;
         roll = $urandom_range(0, 99);
         if (roll < 50) prio = 16'($urandom_range(0, 7));
         else if (roll < 60) prio = 16'h0000;
         else if (roll < 70) prio = 16'hFFFF;
         else prio = 16'($urandom);
         send_request(mode, prio, 16'($urandom));
      end
   endtask

   initial begin : stimulus
      int unsigned n;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_item  <= '0;
      req_quiet  = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Empty queue: peek, pop and the unused mode code must all report the empty error.
      send_request(spq_pkg::MODE_PEEK, 16'h0000, 16'h0000);
      send_request(spq_pkg::MODE_POP, 16'hFFFF, 16'hFFFF);
      send_request(MODE_UNUSED, 16'h1234, 16'h5678);

      // Extreme priorities and tags, plus ties at both ends to check arrival order.
      send_request(spq_pkg::MODE_INSERT, 16'hFFFF, 16'hFFFF);
      send_request(spq_pkg::MODE_INSERT, 16'h0000, 16'h0000);
      send_request(spq_pkg::MODE_INSERT, 16'h0000, 16'h0001);
      send_request(spq_pkg::MODE_INSERT, 16'hFFFF, 16'h1234);
      send_request(spq_pkg::MODE_PEEK, 16'h0000, 16'h0000);
      send_request(MODE_UNUSED, 16'h0000, 16'h0000);
      send_request(spq_pkg::MODE_POP, 16'h0000, 16'h0000);

      // Fill the queue with falling priorities, so each one lands just behind the
      // zero-priority entry, then try one insert too many and look at the full queue.
      for (n = 0; n < spq_pkg::DEPTH - 3; n++)
         send_request(spq_pkg::MODE_INSERT, 16'h8000 - 16'(n * 16'h0800),
                      16'(16'hA000 + n));
      send_request(spq_pkg::MODE_INSERT, 16'h0000, 16'hBEEF);
      send_request(spq_pkg::MODE_PEEK, 16'h0000, 16'h0000);

      run_random(RANDOM_ITEMS);
      req_valid <= 1'b0;

      // Wait for every predicted result, then a few more cycles to catch stray ones.
      // The extra edge lets the last accepted request reach the scoreboard first.
      @(posedge clock);
      while (tracker.predicted.size() > 0) @(posedge clock);
      repeat (5) @(posedge clock);

      $display("Checked %0d results: %0d inserts, %0d pops, %0d peeks.",
               tracker.checked, tracker.inserts, tracker.pops, tracker.peeks);
      $display("Full queue seen %0d times, %0d inserts dropped, %0d empty-queue errors.",
               tracker.full_seen, tracker.full_drops, tracker.empty_errors);
      if (tracker.fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
